[rtl/amge_pkg.sv]
// Package for the adjacency matrix graph engine.
// Holds request codes, default sizes and the controller/datapath interface structs.
// No dependencies.
package amge_pkg;

  localparam int MAX_VERTICES_DEF = 16;

  localparam logic [2:0] REQ_ADD       = 3'd0;
  localparam logic [2:0] REQ_REMOVE    = 3'd1;
  localparam logic [2:0] REQ_TRANSPOSE = 3'd2;
  localparam logic [2:0] REQ_CYCLE     = 3'd3;
  localparam logic [2:0] REQ_PATH      = 3'd4;
  localparam logic [2:0] REQ_INDEGREE  = 3'd5;
  localparam logic [2:0] REQ_OUTDEGREE = 3'd6;
  localparam logic [2:0] REQ_COMPLETE  = 3'd7;

  localparam logic CFG_DIRECTED     = 1'b0;
  localparam logic CFG_VERTEX_COUNT = 1'b1;

  typedef struct packed {
    logic load;
    logic edit_fwd;
    logic edit_mirror;
    logic transpose;
    logic finish;
    logic fin_accept;
    logic fin_answer;
    logic use_degree;
    logic cycle_init;
    logic path_init;
    logic root_next;
    logic root_push;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       a_ok;
    logic       b_ok;
    logic       directed;
    logic       complete;
    logic       root_done;
    logic       root_visited;
    logic       hit;
    logic       last_pop;
  } status_t;

endpackage

[rtl/adjacency_matrix_graph_engine.sv]
// Adjacency matrix graph engine, top level: controller and datapath.
// Edits, transpose, degree and complete requests finish without a search; path and
// cycle searches run a DFS, one DFS step per cycle, and the cycle check walks every root.
// Throughput: one request in flight; the next is taken once the result sits in the
// output register.
// Synchronous reset clears the matrix, sets directed=1 and vertex_count=16.
module adjacency_matrix_graph_engine import amge_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // req_type[2:0], first_vertex[6:3], second_vertex[10:7]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // accepted[0], answer[1], degree[6:2]
);

  cmd_t       cmd;
  status_t    status;
  logic       out_accepted;
  logic       out_answer;
  logic [4:0] out_degree;

  amge_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  amge_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_req       (s_tdata[2:0]),
    .in_first     (s_tdata[6:3]),
    .in_second    (s_tdata[10:7]),
    .cmd          (cmd),
    .status       (status),
    .out_accepted (out_accepted),
    .out_answer   (out_answer),
    .out_degree   (out_degree)
  );

  assign m_tdata = {1'b0, out_degree, out_answer, out_accepted};

endmodule

[rtl/amge_datapath.sv]
// Datapath: adjacency matrix, config registers, DFS marks and stack, result registers.
// Driven by amge_ctrl through cmd_t; depends on amge_pkg.
module amge_datapath import amge_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data,
  input  logic [2:0] in_req,
  input  logic [3:0] in_first,
  input  logic [3:0] in_second,
  input  cmd_t       cmd,
  output status_t    status,
  output logic       out_accepted,
  output logic       out_answer,
  output logic [4:0] out_degree
);

  localparam int V  = MAX_VERTICES;
  localparam int VW = $clog2(V);
  localparam int CW = $clog2(V + 1);

  logic [V-1:0]  rows [V];
  logic [VW-1:0] stack [V];
  logic [V-1:0]  visited;
  logic [V-1:0]  onpath;
  logic [VW-1:0] top;
  logic [CW-1:0] sp;
  logic [CW-1:0] root;
  logic          directed;
  logic [4:0]    vertex_count;
  logic [2:0]    req_q;
  logic [3:0]    a_q;
  logic [3:0]    b_q;
  logic          res_accepted;
  logic          res_answer;
  logic [4:0]    res_degree;

  logic [CW-1:0] n;
  logic [V-1:0]  m;
  logic [VW-1:0] a_idx;
  logic [VW-1:0] b_idx;
  logic [VW+3:0] a_wide;
  logic [VW+3:0] b_wide;
  logic [V-1:0]  top_row;
  logic [V-1:0]  fresh;
  logic [VW-1:0] nx;
  logic [V-1:0]  col_bits;
  logic [CW-1:0] col_cnt;
  logic [CW-1:0] row_cnt;
  logic          complete;
  logic          hit;
  logic          do_push;

  assign n = ({2'b00, vertex_count} > 7'(V)) ? CW'(V) : CW'(vertex_count);
  assign a_wide = (VW + 4)'(a_q);
  assign b_wide = (VW + 4)'(b_q);
  assign a_idx  = a_wide[VW-1:0];
  assign b_idx  = b_wide[VW-1:0];

  always_comb begin
    for (int i = 0; i < V; i++) begin
      m[i] = (8'(i) < 8'(n));
    end
  end

  assign top_row = rows[top] & m;
  assign fresh   = top_row & ~visited;

  always_comb begin
    nx = '0;
    for (int i = V - 1; i >= 0; i--) begin
      if (fresh[i]) begin
        nx = VW'(i);
      end
    end
  end

  always_comb begin
    col_cnt  = '0;
    row_cnt  = '0;
    complete = 1'b1;
    for (int i = 0; i < V; i++) begin
      col_bits[i] = rows[i][a_idx] & m[i];
      col_cnt = col_cnt + CW'(col_bits[i]);
      row_cnt = row_cnt + CW'(rows[a_idx][i] & m[i]);
      if (m[i] && (((rows[i] | (V'(1) << i)) & m) != m)) begin
        complete = 1'b0;
      end
    end
  end

  assign hit = (req_q == REQ_CYCLE) ? |(top_row & onpath) : (top == b_idx);
  assign do_push = (fresh != '0) && (sp < CW'(V));

  assign status.req          = req_q;
  assign status.a_ok         = (8'(a_q) < 8'(n));
  assign status.b_ok         = (8'(b_q) < 8'(n));
  assign status.directed     = directed;
  assign status.complete     = complete;
  assign status.root_done    = (root >= n);
  assign status.root_visited = visited[root[VW-1:0]];
  assign status.hit          = hit;
  assign status.last_pop     = !do_push && (sp == CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      directed     <= 1'b1;
      vertex_count <= 5'd16;
      for (int i = 0; i < V; i++) begin
        rows[i] <= '0;
      end
      visited <= '0;
      onpath  <= '0;
      sp      <= '0;
      root    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DIRECTED:     directed     <= cfg_data[0];
          CFG_VERTEX_COUNT: vertex_count <= cfg_data;
          default:          ;
        endcase
      end
      if (cmd.edit_fwd) begin
        rows[a_idx][b_idx] <= (req_q == REQ_ADD);
      end
      if (cmd.edit_mirror) begin
        rows[b_idx][a_idx] <= (req_q == REQ_ADD);
      end
      if (cmd.transpose) begin
        for (int r = 0; r < V; r++) begin
          for (int c = 0; c < V; c++) begin
            if (m[r] && m[c]) begin
              rows[r][c] <= rows[c][r];
            end
          end
        end
      end
      if (cmd.cycle_init) begin
        visited <= '0;
        onpath  <= '0;
        root    <= '0;
        sp      <= '0;
      end
      if (cmd.path_init) begin
        visited  <= V'(1) << a_idx;
        onpath   <= '0;
        sp       <= CW'(1);
        top      <= a_idx;
        stack[0] <= a_idx;
      end
      if (cmd.root_next) begin
        root <= root + CW'(1);
      end
      if (cmd.root_push) begin
        visited[root[VW-1:0]] <= 1'b1;
        onpath[root[VW-1:0]]  <= 1'b1;
        sp       <= CW'(1);
        top      <= root[VW-1:0];
        stack[0] <= root[VW-1:0];
      end
      if (cmd.step && !hit) begin
        if (do_push) begin
          stack[sp[VW-1:0]] <= nx;
          top               <= nx;
          sp                <= sp + CW'(1);
          visited[nx]       <= 1'b1;
          onpath[nx]        <= 1'b1;
        end else begin
          onpath[top] <= 1'b0;
          sp          <= sp - CW'(1);
          if (sp >= CW'(2)) begin
            top <= stack[VW'(sp - CW'(2))];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= in_req;
      a_q   <= in_first;
      b_q   <= in_second;
    end
    if (cmd.finish) begin
      res_accepted <= cmd.fin_accept;
      res_answer   <= cmd.fin_answer;
      res_degree   <= cmd.use_degree ?
                      5'((req_q == REQ_INDEGREE) ? col_cnt : row_cnt) : 5'd0;
    end
    if (cmd.emit) begin
      out_accepted <= res_accepted;
      out_answer   <= res_answer;
      out_degree   <= res_degree;
    end
  end

  a_sp_bound: assert property (@(posedge clk) disable iff (rst) sp <= CW'(V))
    else $error("stack pointer beyond depth");
  a_step_nonempty: assert property (@(posedge clk) disable iff (rst) cmd.step |-> sp != '0)
    else $error("dfs step on empty stack");
  a_mirror_after_fwd: assert property (@(posedge clk) disable iff (rst)
    cmd.edit_mirror |-> $past(cmd.edit_fwd))
    else $error("mirror edit without forward edit");

endmodule

[rtl/amge_ctrl.sv]
// Controller state machine: handshakes, request decode and DFS sequencing.
// Drives amge_datapath through cmd_t; depends on amge_pkg.
module amge_ctrl import amge_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  output logic    m_tvalid,
  input  logic    m_tready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EDIT_B,
    ST_ROOT,
    ST_STEP,
    ST_RESULT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   reject;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  assign reject =
    (((status.req == REQ_ADD) || (status.req == REQ_REMOVE) || (status.req == REQ_PATH)) &&
     !(status.a_ok && status.b_ok)) ||
    (((status.req == REQ_INDEGREE) || (status.req == REQ_OUTDEGREE)) && !status.a_ok);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (reject) begin
          cmd.finish = 1'b1;
          state_next = ST_RESULT;
        end else begin
          case (status.req)
            REQ_ADD, REQ_REMOVE: begin
              cmd.edit_fwd   = 1'b1;
              cmd.finish     = 1'b1;
              cmd.fin_accept = 1'b1;
              state_next     = status.directed ? ST_RESULT : ST_EDIT_B;
            end
            REQ_TRANSPOSE: begin
              cmd.transpose  = 1'b1;
              cmd.finish     = 1'b1;
              cmd.fin_accept = 1'b1;
              state_next     = ST_RESULT;
            end
            REQ_CYCLE: begin
              cmd.cycle_init = 1'b1;
              state_next     = ST_ROOT;
            end
            REQ_PATH: begin
              cmd.path_init = 1'b1;
              state_next    = ST_STEP;
            end
            REQ_INDEGREE, REQ_OUTDEGREE: begin
              cmd.finish     = 1'b1;
              cmd.fin_accept = 1'b1;
              cmd.use_degree = 1'b1;
              state_next     = ST_RESULT;
            end
            default: begin
              cmd.finish     = 1'b1;
              cmd.fin_accept = 1'b1;
              cmd.fin_answer = status.complete;
              state_next     = ST_RESULT;
            end
          endcase
        end
      end
      ST_EDIT_B: begin
        cmd.edit_mirror = 1'b1;
        state_next      = ST_RESULT;
      end
      ST_ROOT: begin
        if (status.root_done) begin
          cmd.finish     = 1'b1;
          cmd.fin_accept = 1'b1;
          state_next     = ST_RESULT;
        end else if (status.root_visited) begin
          cmd.root_next = 1'b1;
        end else begin
          cmd.root_push = 1'b1;
          state_next    = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (status.hit) begin
          cmd.finish     = 1'b1;
          cmd.fin_accept = 1'b1;
          cmd.fin_answer = 1'b1;
          state_next     = ST_RESULT;
        end else if (status.last_pop) begin
          if (status.req == REQ_CYCLE) begin
            state_next = ST_ROOT;
          end else begin
            cmd.finish     = 1'b1;
            cmd.fin_accept = 1'b1;
            state_next     = ST_RESULT;
          end
        end
      end
      ST_RESULT: begin
        if (!out_valid || m_tready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second transaction accepted while busy");
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_RESULT))
    else $error("output valid without result state");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || m_tready))
    else $error("result overwritten before taken");

endmodule

[tb/tb_adjacency_matrix_graph_engine.sv]
// Testbench for the adjacency matrix graph engine: random and directed requests,
// a built-in graph predictor and a scoreboard class. Depends on rtl/amge_pkg.sv and the top.
module tb_adjacency_matrix_graph_engine import amge_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = 16;

  typedef struct packed {
    logic [4:0] degree;
    logic       answer;
    logic       accepted;
  } graph_result_t;

  class graph_scoreboard;
    logic [NV-1:0] adj [NV];
    logic          directed;
    logic [4:0]    vcount;
    graph_result_t pending[$];
    int            errors;

    function void clear();
      for (int i = 0; i < NV; i++) adj[i] = '0;
      directed = 1'b1;
      vcount = 5'd16;
      pending.delete();
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [4:0] val);
      if (idx == CFG_DIRECTED) directed = val[0];
      else vcount = val;
    endfunction

    function int active_n();
      return (vcount > NV) ? NV : vcount;
    endfunction

    function logic reachable(int n, int src, int dst);
      logic [NV-1:0] seen;
      int stk[$];
      int top;
      seen = '0;
      seen[src] = 1'b1;
      stk.push_back(src);
      while (stk.size() > 0) begin
        top = stk.pop_back();
        if (top == dst) return 1'b1;
        for (int j = 0; j < n; j++)
          if (adj[top][j] && !seen[j]) begin
            seen[j] = 1'b1;
            stk.push_back(j);
          end
      end
      return 1'b0;
    endfunction

    function logic has_cycle(int n);
      logic [NV-1:0] seen, onp, msk, row, fresh;
      int stk[$];
      int top, nx;
      msk = (n >= NV) ? '1 : NV'((1 << n) - 1);
      seen = '0;
      onp = '0;
      for (int r = 0; r < n; r++) begin
        if (seen[r]) continue;
        stk.push_back(r);
        seen[r] = 1'b1;
        onp[r] = 1'b1;
        while (stk.size() > 0) begin
          top = stk[$];
          row = adj[top] & msk;
          if ((row & onp) != 0) return 1'b1;
          fresh = row & ~seen;
          if (fresh != 0) begin
            nx = 0;
            while (!fresh[nx]) nx++;
            seen[nx] = 1'b1;
            onp[nx] = 1'b1;
            stk.push_back(nx);
          end else begin
            onp[top] = 1'b0;
            void'(stk.pop_back());
          end
        end
      end
      return 1'b0;
    endfunction

    function void note_request(logic [2:0] req, int a, int b);
      graph_result_t r;
      int n;
      logic aok, bok, tmp;
      logic [NV-1:0] msk;
      n = active_n();
      msk = (n >= NV) ? '1 : NV'((1 << n) - 1);
      aok = a < n;
      bok = b < n;
      r = '{accepted: 1'b1, answer: 1'b0, degree: 5'd0};
      case (req)
        REQ_ADD, REQ_REMOVE: begin
          if (aok && bok) begin
            adj[a][b] = (req == REQ_ADD);
            if (!directed) adj[b][a] = (req == REQ_ADD);
          end else r.accepted = 1'b0;
        end
        REQ_TRANSPOSE: begin
          for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++) begin
              tmp = adj[i][j];
              adj[i][j] = adj[j][i];
              adj[j][i] = tmp;
            end
        end
        REQ_CYCLE: r.answer = has_cycle(n);
        REQ_PATH: begin
          if (aok && bok) r.answer = reachable(n, a, b);
          else r.accepted = 1'b0;
        end
        REQ_INDEGREE: begin
          if (aok) begin
            for (int i = 0; i < n; i++) r.degree += adj[i][a];
          end else r.accepted = 1'b0;
        end
        REQ_OUTDEGREE: begin
          if (aok) r.degree = 5'($countones(adj[a] & msk));
          else r.accepted = 1'b0;
        end
        default: begin
          r.answer = 1'b1;
          for (int i = 0; i < n; i++)
            if (((adj[i] | (NV'(1) << i)) & msk) != msk) r.answer = 1'b0;
        end
      endcase
      pending.push_back(r);
    endfunction

    task automatic report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task automatic check_result(logic [7:0] data);
      graph_result_t want;
      graph_result_t got;
      got = graph_result_t'(data[6:0]);
      if (data[7] !== 1'b0) report("padding bit set");
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", data));
      end else begin
        want = pending.pop_front();
        if (got.accepted !== want.accepted)
          report($sformatf("accepted %b want %b", got.accepted, want.accepted));
        if (got.answer !== want.answer)
          report($sformatf("answer %b want %b", got.answer, want.answer));
        if (got.degree !== want.degree)
          report($sformatf("degree %0d want %0d", got.degree, want.degree));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [4:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;

  graph_scoreboard sb;
  int  cycles;
  int  sink_idle_pct;
  int  hold_off;
  int  src_idle_pct;

  adjacency_matrix_graph_engine dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 1500000) begin
        $display("tb_adjacency_matrix_graph_engine: FAIL");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready && !rst) sb.check_result(m_tdata);
      if (hold_off > 0) begin
        hold_off--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // valid stays high after the accepting edge; the next driver call updates it
  task automatic send_request(logic [2:0] req, logic [3:0] a, logic [3:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, b, a, req};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(req, a, b);
  endtask

  task automatic write_reg(logic idx, logic [4:0] val);
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic random_phase(int count, logic [4:0] nmax);
    logic [2:0] req;
    logic [3:0] a, b;
    for (int i = 0; i < count; i++) begin
      req = ($urandom_range(99) < 45) ? 3'($urandom_range(1)) : 3'($urandom_range(7));
      if ($urandom_range(9) == 0) begin
        a = 4'($urandom_range(15));
        b = 4'($urandom_range(15));
      end else begin
        a = 4'($urandom_range(nmax > 0 ? nmax - 1 : 0));
        b = 4'($urandom_range(nmax > 0 ? nmax - 1 : 0));
      end
      send_request(req, a, b);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_DIRECTED;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    hold_off = 0;
    sink_idle_pct = 0;
    src_idle_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty graph, extremes, self-loop, path to itself
    send_request(REQ_COMPLETE, 4'd0, 4'd0);
    send_request(REQ_CYCLE, 4'd0, 4'd0);
    send_request(REQ_PATH, 4'd15, 4'd15);
    send_request(REQ_ADD, 4'd0, 4'd15);
    send_request(REQ_ADD, 4'd15, 4'd7);
    send_request(REQ_PATH, 4'd0, 4'd7);
    send_request(REQ_PATH, 4'd7, 4'd0);
    send_request(REQ_INDEGREE, 4'd15, 4'd0);
    send_request(REQ_OUTDEGREE, 4'd15, 4'd0);
    send_request(REQ_TRANSPOSE, 4'd0, 4'd0);
    send_request(REQ_PATH, 4'd7, 4'd0);
    send_request(REQ_CYCLE, 4'd0, 4'd0);
    send_request(REQ_ADD, 4'd5, 4'd5);
    send_request(REQ_CYCLE, 4'd0, 4'd0);
    send_request(REQ_REMOVE, 4'd5, 4'd5);
    send_request(REQ_REMOVE, 4'd15, 4'd0);
    write_reg(CFG_VERTEX_COUNT, 5'd2);
    send_request(REQ_ADD, 4'd2, 4'd0);
    send_request(REQ_ADD, 4'd0, 4'd1);
    send_request(REQ_ADD, 4'd1, 4'd0);
    send_request(REQ_COMPLETE, 4'd0, 4'd0);
    send_request(REQ_INDEGREE, 4'd1, 4'd9);
    write_reg(CFG_VERTEX_COUNT, 5'd0);
    send_request(REQ_ADD, 4'd0, 4'd0);
    send_request(REQ_COMPLETE, 4'd0, 4'd0);
    send_request(REQ_CYCLE, 4'd0, 4'd0);

    // no idling stretch, directed, full size
    write_reg(CFG_VERTEX_COUNT, 5'd16);
    random_phase(200, 5'd16);

    // long receiver hold-off while requests keep coming
    sink_idle_pct = 37;
    src_idle_pct = 37;
    hold_off = 300;
    random_phase(200, 5'd16);

    write_reg(CFG_DIRECTED, 5'd0);
    random_phase(200, 5'd16);
    write_reg(CFG_VERTEX_COUNT, 5'd5);
    random_phase(150, 5'd5);
    write_reg(CFG_DIRECTED, 5'd1);
    random_phase(150, 5'd5);
    write_reg(CFG_VERTEX_COUNT, 5'd31);
    random_phase(100, 5'd16);
    write_reg(CFG_VERTEX_COUNT, 5'd1);
    random_phase(50, 5'd1);
    write_reg(CFG_VERTEX_COUNT, 5'd9);
    random_phase(100, 5'd9);

    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("tb_adjacency_matrix_graph_engine: PASS");
    else $display("tb_adjacency_matrix_graph_engine: FAIL");
    $finish;
  end
endmodule

[sim.f]
rtl/amge_pkg.sv
rtl/amge_datapath.sv
rtl/amge_ctrl.sv
rtl/adjacency_matrix_graph_engine.sv
tb/tb_adjacency_matrix_graph_engine.sv
